/* design/shuffled_id_generator_core_defines.svh */
// assertion macros of the shuffled id generator, used by its top level
// no dependencies; only the top-level core includes this header
`ifndef SHUFFLED_ID_GENERATOR_CORE_DEFINES_SVH
`define SHUFFLED_ID_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication check
`define SIG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication check
`define SIG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SIG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SIG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/sig_pkg.sv */
// shared types, codes and constants of the shuffled id generator
// no dependencies; used by the interfaces, controller, datapath and top level
package sig_pkg;

  // table geometry
  localparam int TABLE_DEPTH     = 65536;
  localparam int IDX_W           = $clog2(TABLE_DEPTH);
  localparam int MAX_REQ_DEFAULT = 16;
  localparam int LG_MAX          = 4;

  // field widths
  localparam int CMD_W    = 2;
  localparam int REQ_W    = 4;
  localparam int RND_W    = 15;
  localparam int LG_W     = 3;
  localparam int ACT_W    = 5;
  localparam int CFG_IX_W = 2;
  localparam int CFG_D_W  = 5;

  // input command codes
  localparam logic [CMD_W-1:0] CMD_DRAW    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SPREAD  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IX_W-1:0] CFG_PART_LG2 = 2'd0;
  localparam logic [CFG_IX_W-1:0] CFG_ACTIVE   = 2'd1;

  // configuration reset values
  localparam logic [LG_W-1:0]  LG_RESET  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RESET = 5'd1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_WR_HI,
    ST_WR_LO,
    ST_SWEEP,
    ST_SPREAD,
    ST_DONE
  } ctrl_state_t;

  // table write source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_SLOT2,
    WR_SLOT1,
    WR_SWEEP
  } wr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    calc;
    logic    rd_en;
    wr_sel_t wr_sel;
    logic    spread;
    logic    load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic out_pending;
  } dp_stat_t;

endpackage

/* design/sig_in_if.sv */
// input item channel of the shuffled id generator
// depends on sig_pkg for field widths
interface sig_in_if import sig_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [REQ_W-1:0] requester;
  logic [RND_W-1:0] random_value;

  modport source (output valid, output command, output requester, output random_value,
                  input ready);
  modport sink (input valid, input command, input requester, input random_value,
                output ready);
endinterface

/* design/sig_out_if.sv */
// result channel of the shuffled id generator
// depends on sig_pkg for field widths
interface sig_out_if import sig_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] id_value;

  modport source (output valid, output id_value, input ready);
  modport sink (input valid, input id_value, output ready);
endinterface

/* design/sig_cfg_if.sv */
// configuration write channel of the shuffled id generator
// depends on sig_pkg for field widths
interface sig_cfg_if import sig_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CFG_IX_W-1:0] addr;
  logic [CFG_D_W-1:0]  data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

/* design/shuffled_id_generator_core.sv */
// Shuffled id generator: hands out 16-bit ids from a 65536-entry permutation
// table with per-requester cursors. After reset the table is filled with the
// identity permutation by a clearing pass, during which no item is accepted
// (configuration writes are taken at any time). One item is in work at a
// time: a draw passes through capture, slot arithmetic, one dual read of the
// table, one write per swapped slot and result load, the two writes kept apart
// by the single write port of the table memory; a restart runs the same
// clearing pass. The next item is taken while a result still waits in the
// output register. Depends on sig_pkg, the channel interfaces, sig_ctrl,
// sig_dpath and the assertion macro header.
`include "shuffled_id_generator_core_defines.svh"

module shuffled_id_generator_core import sig_pkg::*; #(
  parameter int MAX_REQUESTERS = MAX_REQ_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  sig_in_if.sink    in_chan,
  sig_out_if.source out_chan,
  sig_cfg_if.sink   cfg_chan
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration writes never stall
  assign cfg_chan.ready = 1'b1;

  // controller
  sig_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .in_ready   (in_chan.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath
  sig_dpath #(
    .MAX_REQUESTERS (MAX_REQUESTERS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (in_chan.command),
    .in_requester    (in_chan.requester),
    .in_random_value (in_chan.random_value),
    .cfg_valid       (cfg_chan.valid),
    .cfg_addr        (cfg_chan.addr),
    .cfg_data        (cfg_chan.data),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_id_value    (out_chan.id_value)
  );

  // one item in work at a time
  `SIG_ASSERT_NXT(a_one_item, clk, rst_n, in_chan.valid && in_chan.ready, !in_chan.ready)
  // a pending result is never overwritten
  `SIG_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.load_out, !stat.out_pending)
  // table reads and writes never share a cycle
  `SIG_ASSERT_IMP(a_rd_wr_apart, clk, rst_n, cmd.rd_en, cmd.wr_sel == WR_NONE)

endmodule

/* design/sig_ctrl.sv */
// sequencing state machine of the shuffled id generator
// depends on sig_pkg for the state type and the command/status structs
module sig_ctrl import sig_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd
);

  ctrl_state_t state_r, state_nxt;

  // state register, reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (stat.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_command)
            CMD_DRAW:    state_nxt = ST_CALC;
            CMD_RESTART: state_nxt = ST_SWEEP;
            CMD_SPREAD:  state_nxt = ST_SPREAD;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CALC:   state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_WR_HI;
      ST_WR_HI:  state_nxt = ST_WR_LO;
      ST_WR_LO:  state_nxt = ST_DONE;
      ST_SWEEP: begin
        if (stat.sweep_last) state_nxt = ST_DONE;
      end
      ST_SPREAD: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!stat.out_pending) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_INIT:   cmd.wr_sel = WR_SWEEP;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_CALC:   cmd.calc   = 1'b1;
      ST_READ:   cmd.rd_en  = 1'b1;
      ST_WR_HI:  cmd.wr_sel = WR_SLOT2;
      ST_WR_LO:  cmd.wr_sel = WR_SLOT1;
      ST_SWEEP:  cmd.wr_sel = WR_SWEEP;
      ST_SPREAD: cmd.spread = 1'b1;
      ST_DONE:   cmd.load_out = !stat.out_pending;
      default:   cmd = '0;
    endcase
  end

endmodule

/* design/sig_dpath.sv */
// datapath of the shuffled id generator: config registers, cursors,
// permutation memory, slot arithmetic and output register; uses sig_pkg
module sig_dpath import sig_pkg::*; #(
  parameter int MAX_REQUESTERS = MAX_REQ_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [REQ_W-1:0]    in_requester,
  input  logic [RND_W-1:0]    in_random_value,
  input  logic                cfg_valid,
  input  logic [CFG_IX_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0]  cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    out_id_value
);

  localparam int CUR_W = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
  localparam logic [ACT_W-1:0] MAX_N = ACT_W'(MAX_REQUESTERS);
  localparam logic [CUR_W-1:0] CUR_LAST = CUR_W'(MAX_REQUESTERS - 1);

  logic [LG_W-1:0]  lg_r;
  logic [ACT_W-1:0] act_r;

  logic [CMD_W-1:0] cmd_r;
  logic [REQ_W-1:0] req_r;
  logic [RND_W-1:0] rnd_r;

  logic [IDX_W-1:0] cursor_r [MAX_REQUESTERS];
  logic [IDX_W-1:0] i1_r, i2_r;
  logic [IDX_W-1:0] sweep_r;
  logic [IDX_W-1:0] rd_a_r, rd_b_r;
  logic [IDX_W-1:0] mem [TABLE_DEPTH];

  logic             out_valid_r;
  logic [IDX_W-1:0] out_id_r;

  logic [LG_W-1:0]  lg_eff;
  logic [IDX_W-1:0] pmask, count, rq_ext, cur_sel, i1_c, sum_c, i2_c;
  logic [REQ_W-1:0] rq;
  logic [CUR_W-1:0] ci;
  logic [ACT_W-1:0] n_eff;
  logic [4:0]       shamt;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr, wr_data;

  // configuration writes, addresses beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r  <= LG_RESET;
      act_r <= ACT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_PART_LG2: lg_r  <= cfg_data[LG_W-1:0];
        CFG_ACTIVE:   act_r <= cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_command;
      req_r <= in_requester;
      rnd_r <= in_random_value;
    end
  end

  // partition geometry
  always_comb begin
    lg_eff = (lg_r > LG_W'(LG_MAX)) ? LG_W'(LG_MAX) : lg_r;
    count  = IDX_W'(1) << lg_eff;
    pmask  = count - IDX_W'(1);
    shamt  = 5'(IDX_W) - {2'b00, lg_eff};
    n_eff  = (act_r > MAX_N) ? MAX_N : act_r;
  end

  // slot arithmetic from the selected cursor
  always_comb begin
    rq      = req_r & pmask[REQ_W-1:0];
    ci      = ({1'b0, rq} < (REQ_W+1)'(MAX_REQUESTERS)) ? rq[CUR_W-1:0] : CUR_LAST;
    rq_ext  = IDX_W'(rq);
    cur_sel = cursor_r[ci];
    i1_c    = (cur_sel & ~pmask) | rq_ext;
    sum_c   = i1_c + IDX_W'(rnd_r);
    i2_c    = (sum_c & ~pmask) | rq_ext;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      i1_r <= i1_c;
      i2_r <= i2_c;
    end
  end

  // cursors: clear during the sweep, spread, or advance on a draw
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_REQUESTERS; k++) begin
      if (cmd.wr_sel == WR_SWEEP) begin
        cursor_r[k] <= '0;
      end else if (cmd.spread) begin
        if (ACT_W'(k) < n_eff) cursor_r[k] <= IDX_W'(k) << shamt;
      end else if (cmd.calc && (ci == CUR_W'(k))) begin
        cursor_r[k] <= cur_sel + count;
      end
    end
  end

  // sweep counter wraps back to zero at the end of each pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.wr_sel == WR_SWEEP) begin
      sweep_r <= sweep_r + IDX_W'(1);
    end
  end

  // table write source
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = sweep_r;
    wr_data = sweep_r;
    case (cmd.wr_sel)
      WR_SLOT2: begin
        wr_addr = i2_r;
        wr_data = rd_a_r;
      end
      WR_SLOT1: begin
        wr_addr = i1_r;
        wr_data = rd_b_r;
      end
      WR_SWEEP: ;
      default:  wr_en = 1'b0;
    endcase
  end

  // permutation memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) begin
      rd_a_r <= mem[i1_r];
      rd_b_r <= mem[i2_r];
    end
  end

  // output register, draws return the old entry of the second slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_id_r <= (cmd_r == CMD_DRAW) ? rd_b_r : '0;
  end

  assign out_valid        = out_valid_r;
  assign out_id_value     = out_id_r;
  assign stat.sweep_last  = (sweep_r == '1);
  assign stat.out_pending = out_valid_r && !out_ready;

endmodule
